// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the keystream cipher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCC_ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");
`define HCC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define HCC_ASSERT_IMPLY(label, clk, rst, pre, post)
`define HCC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// Types, constants and helpers shared by the keystream cipher modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hcc_pkg;

  localparam int MAGIC_LEN_DEF = 13;
  localparam int IV_LEN        = 16;
  localparam int HP_W          = 5;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] MAGIC_BYTES [16] = '{
    8'h42, 8'h52, 8'h45, 8'h45, 8'h5A, 8'h45, 8'h2D, 8'h53,
    8'h59, 8'h4E, 8'h43, 8'h2D, 8'h31, 8'h00, 8'h00, 8'h00
  };

  localparam logic [255:0] SHA_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIPHER_ON = 3'd0,
    REG_DIRECTION = 3'd1,
    REG_KEY0      = 3'd2,
    REG_KEY1      = 3'd3,
    REG_KEY2      = 3'd4,
    REG_KEY3      = 3'd5
  } reg_idx_t;

  localparam logic DIR_ENC = 1'b0;

  typedef enum logic [2:0] {
    CK_NONE   = 3'd0,
    CK_BYPASS = 3'd1,
    CK_ECHO   = 3'd2,
    CK_BAD    = 3'd3,
    CK_EMPTY  = 3'd4,
    CK_BODY   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t    kind;
    logic         magic;
    logic         start;
    logic         endm;
    logic         last;
    logic [7:0]   data;
    logic [127:0] iv;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic emitting;
    logic hash_wait;
  } back_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hcc_queue.sv =====
// ----------------------------------------------------------------------------
// hcc_queue
// Two-entry command queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none
module hcc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire hcc_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output hcc_pkg::cmd_t      pop_data
);
  import hcc_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hcc_front.sv =====
// ----------------------------------------------------------------------------
// hcc_front
// Accepts input beats, tracks framing state and classifies each beat.
// ----------------------------------------------------------------------------
`default_nettype none
module hcc_front #(
  parameter int MAGIC_LEN = hcc_pkg::MAGIC_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cipher_on,
  input  wire logic       direction,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       msg_last,
  input  wire logic       q_full,
  output logic            push,
  output hcc_pkg::cmd_t   cmd
);
  import hcc_pkg::*;

  localparam logic [HP_W-1:0] MAGIC_END = HP_W'(MAGIC_LEN);
  localparam logic [HP_W:0]   IV_END    = (HP_W + 1)'(IV_LEN);
  localparam logic [HP_W:0]   DEC_END   = (HP_W + 1)'(MAGIC_LEN + IV_LEN);

  logic [HP_W-1:0] header_pos, header_pos_next;
  logic [127:0]    iv_store, iv_store_next;
  logic            dropping, dropping_next;
  logic [HP_W:0]   hp_inc;
  logic [3:0]      iv_idx;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign hp_inc   = (HP_W + 1)'(header_pos) + 1'b1;

  always_comb begin
    cmd             = '0;
    cmd.kind        = CK_NONE;
    cmd.data        = in_byte;
    cmd.last        = msg_last;
    header_pos_next = header_pos;
    dropping_next   = dropping;
    iv_store_next   = iv_store;
    iv_idx          = header_pos[3:0];
    if (!cipher_on) begin
      cmd.kind = CK_BYPASS;
    end else if (dropping) begin
      if (msg_last) begin
        cmd.endm        = 1'b1;
        header_pos_next = '0;
        dropping_next   = 1'b0;
      end
    end else begin
      if (direction == DIR_ENC) begin
        if (header_pos < HP_W'(IV_LEN)) begin
          cmd.magic = (header_pos == '0);
          iv_store_next[{~iv_idx, 3'b000} +: 8] = in_byte;
          cmd.start       = (hp_inc == IV_END);
          header_pos_next = header_pos + 1'b1;
          cmd.kind        = CK_ECHO;
        end else begin
          cmd.kind = CK_BODY;
        end
      end else begin
        if (header_pos < MAGIC_END) begin
          if (in_byte != MAGIC_BYTES[header_pos[3:0]]) begin
            cmd.kind = CK_BAD;
            if (!msg_last) begin
              dropping_next = 1'b1;
            end
          end else begin
            header_pos_next = header_pos + 1'b1;
            cmd.kind        = msg_last ? CK_EMPTY : CK_NONE;
          end
        end else if ((HP_W + 1)'(header_pos) < DEC_END) begin
          iv_idx = 4'(header_pos - MAGIC_END);
          iv_store_next[{~iv_idx, 3'b000} +: 8] = in_byte;
          cmd.start       = (hp_inc == DEC_END);
          header_pos_next = header_pos + 1'b1;
          cmd.kind        = msg_last ? CK_EMPTY : CK_NONE;
        end else begin
          cmd.kind = CK_BODY;
        end
      end
      if (msg_last) begin
        cmd.endm        = 1'b1;
        header_pos_next = '0;
        dropping_next   = 1'b0;
      end
    end
    cmd.iv = iv_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos <= '0;
      dropping   <= 1'b0;
      iv_store   <= '0;
    end else if (push) begin
      header_pos <= header_pos_next;
      dropping   <= dropping_next;
      iv_store   <= iv_store_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hcc_sha.sv =====
// ----------------------------------------------------------------------------
// hcc_sha
// Iterative SHA-256 compression, one round per cycle, fixed initial state.
// ----------------------------------------------------------------------------
`default_nettype none
module hcc_sha (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [511:0] block,
  output logic              done,
  output logic [255:0]      digest
);
  import hcc_pkg::*;

  logic [31:0] hw [8];
  logic [31:0] w  [16];
  logic [5:0]  round;
  logic        busy;
  logic        fin;
  logic [31:0] t1, t2, w_new, s0, s1;

  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1 = hw[7] + (rotr(hw[4], 6) ^ rotr(hw[4], 11) ^ rotr(hw[4], 25))
       + ((hw[4] & hw[5]) ^ (~hw[4] & hw[6])) + SHA_K[round] + w[0];
    t2 = (rotr(hw[0], 2) ^ rotr(hw[0], 13) ^ rotr(hw[0], 22))
       + ((hw[0] & hw[1]) ^ (hw[0] & hw[2]) ^ (hw[1] & hw[2]));
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= SHA_INIT[255 - 32*i -: 32];
      end
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32*i -: 32];
      end
    end else if (busy) begin
      hw[7] <= hw[6];
      hw[6] <= hw[5];
      hw[5] <= hw[4];
      hw[4] <= hw[3] + t1;
      hw[3] <= hw[2];
      hw[2] <= hw[1];
      hw[1] <= hw[0];
      hw[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
    if (fin) begin
      for (int i = 0; i < 8; i++) begin
        digest[255 - 32*i -: 32] <= SHA_INIT[255 - 32*i -: 32] + hw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 1'b1;
        if (round == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hcc_back.sv =====
// ----------------------------------------------------------------------------
// hcc_back
// Executes queued commands: header emission, keystream XOR, rekeying.
// ----------------------------------------------------------------------------
`default_nettype none
module hcc_back #(
  parameter int MAGIC_LEN = hcc_pkg::MAGIC_LEN_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire hcc_pkg::cmd_t  q_data,
  output logic                q_pop,
  input  wire logic [255:0]   key,
  output logic                sha_start,
  output logic [511:0]        sha_block,
  input  wire logic           sha_done,
  input  wire logic [255:0]   sha_digest,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                bad_format,
  output logic                empty_body,
  output hcc_pkg::back_stat_t stat
);
  import hcc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MAGIC  = 5'b00010,
    ST_EMIT   = 5'b00100,
    ST_HSTART = 5'b01000,
    ST_HWAIT  = 5'b10000
  } state_t;

  state_t       state;
  cmd_t         cmd;
  logic [4:0]   mcnt;
  logic [4:0]   bbpos;
  logic [255:0] key_block;
  logic         hash_iv;
  logic         out_free;
  logic [7:0]   ks;
  logic         need_hash;
  logic         out_load;
  logic [7:0]   emit_byte;
  logic         emit_last;
  logic         emit_bad;
  logic         emit_empty;

  assign out_free  = !out_valid || !out_stall;
  assign ks        = key_block[{~bbpos, 3'b000} +: 8];
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign sha_start = (state == ST_HSTART);
  assign sha_block = hash_iv
    ? {key, cmd.iv, 32'h80000000, 64'd0, 32'd384}
    : {key_block, 32'h80000000, 192'd0, 32'd256};
  assign need_hash = cmd.start || (cmd.kind == CK_BODY && bbpos == 5'd31);
  assign out_load  = out_free &&
                     ((state == ST_MAGIC) || (state == ST_EMIT && cmd.kind != CK_NONE));

  assign stat.idle      = (state == ST_IDLE);
  assign stat.emitting  = (state == ST_MAGIC) || (state == ST_EMIT);
  assign stat.hash_wait = (state == ST_HWAIT);

  always_comb begin
    emit_byte  = '0;
    emit_last  = cmd.last;
    emit_bad   = 1'b0;
    emit_empty = 1'b0;
    if (state == ST_MAGIC) begin
      emit_byte = MAGIC_BYTES[mcnt[3:0]];
      emit_last = 1'b0;
    end else begin
      case (cmd.kind)
        CK_BYPASS: emit_byte = cmd.data;
        CK_ECHO: begin
          emit_byte  = cmd.data;
          emit_empty = cmd.last;
        end
        CK_BAD: begin
          emit_last = 1'b1;
          emit_bad  = 1'b1;
        end
        CK_EMPTY: begin
          emit_last  = 1'b1;
          emit_empty = 1'b1;
        end
        CK_BODY: emit_byte = cmd.data ^ ks;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bbpos     <= '0;
      key_block <= '0;
      mcnt      <= '0;
      hash_iv   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        out_byte   <= emit_byte;
        out_last   <= emit_last;
        bad_format <= emit_bad;
        empty_body <= emit_empty;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= q_data;
            mcnt  <= '0;
            state <= q_data.magic ? ST_MAGIC : ST_EMIT;
          end
        end
        ST_MAGIC: begin
          if (out_free) begin
            mcnt <= mcnt + 1'b1;
            if (mcnt == 5'(MAGIC_LEN - 1)) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (cmd.kind == CK_NONE || out_free) begin
            if (need_hash) begin
              hash_iv <= cmd.start;
              state   <= ST_HSTART;
            end else begin
              state <= ST_IDLE;
              if (cmd.endm) begin
                bbpos <= '0;
              end else if (cmd.kind == CK_BODY) begin
                bbpos <= bbpos + 1'b1;
              end
            end
          end
        end
        ST_HSTART: begin
          state <= ST_HWAIT;
        end
        ST_HWAIT: begin
          if (sha_done) begin
            key_block <= sha_digest;
            bbpos     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hash_chain_keystream_cipher.sv =====
// ----------------------------------------------------------------------------
// hash_chain_keystream_cipher
// Framed byte stream cipher with a SHA-256 hash-chain keystream.
// ----------------------------------------------------------------------------
// Usage: bytes enter on in_valid/in_stall with msg_last on the final byte of a
// message; results leave on out_valid/out_stall with out_last, bad_format and
// empty_body flags. Registers are written on cfg_valid/cfg_ready (always
// ready) by cfg_index: cipher_on, direction, key 0-3. The user must write
// them only while the block is idle; the block itself does not enforce it.
// A front stage classifies each beat into a two-entry queue; the back stage
// emits results through one output register and runs the hash core.
// The back stage pops a new command only after the previous one is emitted;
// the first encrypt beat emits the magic header, one beat per cycle while
// out_stall is low. Keystream start and every 32nd body byte add a SHA-256
// compression (one round per cycle) before the back stage continues.
// Reset clears framing state, key block and registers; no clearing pass.
// When out_stall is high the result register holds, the back stage stops,
// the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hash_chain_keystream_cipher #(
  parameter int MAGIC_LEN = hcc_pkg::MAGIC_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           msg_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_last,
  output logic                                bad_format,
  output logic                                empty_body,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                    cfg_data
);
  import hcc_pkg::*;

  logic         cipher_on;
  logic         direction;
  logic [63:0]  key_word [4];
  logic         push, q_full, q_valid, q_pop;
  cmd_t         push_cmd, q_cmd;
  logic         sha_start, sha_done;
  logic [511:0] sha_block;
  logic [255:0] sha_digest;
  back_stat_t   stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_on <= 1'b0;
      direction <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CIPHER_ON: cipher_on   <= cfg_data[0];
        REG_DIRECTION: direction   <= cfg_data[0];
        REG_KEY0:      key_word[0] <= cfg_data;
        REG_KEY1:      key_word[1] <= cfg_data;
        REG_KEY2:      key_word[2] <= cfg_data;
        REG_KEY3:      key_word[3] <= cfg_data;
        default:       ;
      endcase
    end
  end

  hcc_front #(.MAGIC_LEN(MAGIC_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cipher_on (cipher_on),
    .direction (direction),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  hcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_cmd)
  );

  hcc_sha u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .block  (sha_block),
    .done   (sha_done),
    .digest (sha_digest)
  );

  hcc_back #(.MAGIC_LEN(MAGIC_LEN)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_cmd),
    .q_pop      (q_pop),
    .key        ({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .sha_start  (sha_start),
    .sha_block  (sha_block),
    .sha_done   (sha_done),
    .sha_digest (sha_digest),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_format (bad_format),
    .empty_body (empty_body),
    .stat       (stat)
  );

  `HCC_ASSERT_IMPLY(a_done_in_wait, clk, rst, sha_done, stat.hash_wait)
  `HCC_ASSERT_IMPLY(a_out_from_emit, clk, rst, $rose(out_valid), $past(stat.emitting))
  `HCC_ASSERT_NEXT(a_start_waits, clk, rst, sha_start, stat.hash_wait)
  `HCC_ASSERT_IMPLY(a_pop_when_idle, clk, rst, q_pop, stat.idle)
endmodule
`default_nettype wire

// ===== dv/hash_chain_keystream_cipher_test.sv =====
// ----------------------------------------------------------------------------
// hash_chain_keystream_cipher_test
// Self-checking bench for the framed SHA-256 hash-chain byte cipher. A short
// table of directed beats (bypass, header-only messages, magic mismatch with
// drop, empty body) is followed by random framed messages under several
// register settings and idling phases. Output beats are checked against
// fixed results or an in-bench model of framing, IV capture and keystream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module hash_chain_keystream_cipher_test;
  import hcc_pkg::*;

  localparam int MLEN = MAGIC_LEN_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 100;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
    logic       empty;
  } beat_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [63:0] wdata;
    logic [7:0]  data;
    logic        last;
    bit          fixed;
    beat_t       result;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        msg_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        bad_format;
  logic        empty_body;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  hash_chain_keystream_cipher u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .msg_last(msg_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_last(out_last), .bad_format(bad_format), .empty_body(empty_body),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cipher model state
  logic        m_cipher_on, m_decrypt;
  logic [63:0] m_key [4];
  int          m_hdr_pos, m_ks_pos;
  logic [7:0]  m_iv [16];
  logic [31:0] m_kblk [8];
  bit          m_dropping;

  beat_t       expected_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_cnt = 0;
  int          phase_items;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress(input logic [31:0] blk [16]);
    logic [31:0] w [16];
    logic [31:0] h [8];
    logic [31:0] a, b, wt, t1, t2;
    w = blk;
    for (int i = 0; i < 8; i++) h[i] = SHA_INIT[255-32*i -: 32];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        a = w[(t-15) & 15];
        b = w[(t-2) & 15];
        wt = w[t & 15] + (ror32(a, 7) ^ ror32(a, 18) ^ (a >> 3)) + w[(t-7) & 15]
           + (ror32(b, 17) ^ ror32(b, 19) ^ (b >> 10));
        w[t & 15] = wt;
      end
      t1 = h[7] + (ror32(h[4], 6) ^ ror32(h[4], 11) ^ ror32(h[4], 25))
         + ((h[4] & h[5]) ^ (~h[4] & h[6])) + SHA_K[t] + wt;
      t2 = (ror32(h[0], 2) ^ ror32(h[0], 13) ^ ror32(h[0], 22))
         + ((h[0] & h[1]) ^ (h[0] & h[2]) ^ (h[1] & h[2]));
      h[7] = h[6]; h[6] = h[5]; h[5] = h[4]; h[4] = h[3] + t1;
      h[3] = h[2]; h[2] = h[1]; h[1] = h[0]; h[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) m_kblk[i] = SHA_INIT[255-32*i -: 32] + h[i];
    m_ks_pos = 0;
  endfunction

  function automatic void keystream_start();
    logic [31:0] blk [16];
    for (int i = 0; i < 4; i++) begin
      blk[2*i]   = m_key[i][63:32];
      blk[2*i+1] = m_key[i][31:0];
      blk[8+i]   = {m_iv[4*i], m_iv[4*i+1], m_iv[4*i+2], m_iv[4*i+3]};
    end
    blk[12] = 32'h8000_0000; blk[13] = '0; blk[14] = '0; blk[15] = 32'd384;
    sha_compress(blk);
  endfunction

  function automatic void keystream_next();
    logic [31:0] blk [16];
    for (int i = 0; i < 8; i++) blk[i] = m_kblk[i];
    blk[8] = 32'h8000_0000;
    for (int i = 9; i < 15; i++) blk[i] = '0;
    blk[15] = 32'd256;
    sha_compress(blk);
  endfunction

  function automatic beat_t mk(input logic [7:0] d, input logic l, bd, em);
    beat_t r;
    r.data = d; r.last = l; r.bad = bd; r.empty = em;
    return r;
  endfunction

  function automatic void end_msg();
    m_hdr_pos = 0; m_ks_pos = 0; m_dropping = 0;
  endfunction

  function automatic void cipher_predict(input logic [7:0] d, input logic l,
                                         inout beat_t res [$]);
    bit body;
    int pos;
    logic [7:0] ks;
    if (!m_cipher_on) begin
      res.push_back(mk(d, l, 0, 0));
      return;
    end
    if (m_dropping) begin
      if (l) end_msg();
      return;
    end
    m_hdr_pos &= 31;
    if (!m_decrypt) begin
      body = m_hdr_pos >= IV_LEN;
      if (!body) begin
        if (m_hdr_pos == 0)
          for (int i = 0; i < MLEN; i++) res.push_back(mk(MAGIC_BYTES[i], 0, 0, 0));
        m_iv[m_hdr_pos & 15] = d;
        m_hdr_pos++;
        if (m_hdr_pos == IV_LEN) keystream_start();
        res.push_back(mk(d, l, 0, l));
      end
    end else begin
      body = m_hdr_pos >= MLEN + IV_LEN;
      if (m_hdr_pos < MLEN) begin
        if (d != MAGIC_BYTES[m_hdr_pos & 15]) begin
          res.push_back(mk(0, 1, 1, 0));
          if (l) end_msg();
          else m_dropping = 1;
          return;
        end
        m_hdr_pos++;
        if (l) res.push_back(mk(0, 1, 0, 1));
      end else if (!body) begin
        m_iv[(m_hdr_pos - MLEN) & 15] = d;
        m_hdr_pos++;
        if (m_hdr_pos == MLEN + IV_LEN) keystream_start();
        if (l) res.push_back(mk(0, 1, 0, 1));
      end
    end
    if (body) begin
      pos = m_ks_pos & 31;
      ks = 8'(m_kblk[pos >> 2] >> (24 - 8 * (pos & 3)));
      res.push_back(mk(d ^ ks, l, 0, 0));
      m_ks_pos = pos + 1;
      if (m_ks_pos == 32) keystream_next();
    end
    if (l) end_msg();
  endfunction

  // caller sits at a falling edge; returns at a falling edge
  task automatic send_beat(input logic [7:0] d, input logic l,
                           input bit fixed = 0, input beat_t fixed_res = '{default: 0});
    beat_t res [$];
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= d;
    msg_last <= l;
    do @(posedge clk); while (in_stall);
    cipher_predict(d, l, res);
    if (fixed) expected_q.push_back(fixed_res);
    else foreach (res[i]) expected_q.push_back(res[i]);
    phase_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained(input bit settle);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CIPHER_ON: m_cipher_on = v[0];
      REG_DIRECTION: m_decrypt = v[0];
      default: m_key[idx - REG_KEY0] = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message();
    int plen, cut;
    bit broken;
    logic [7:0] d;
    plen = ($urandom_range(7) == 0) ? $urandom_range(70, 33) : $urandom_range(12);
    if (!m_cipher_on) begin
      plen = $urandom_range(8, 1);
      for (int i = 0; i < plen; i++) send_beat(8'($urandom), i == plen - 1);
    end else if (!m_decrypt) begin
      cut = ($urandom_range(7) == 0) ? $urandom_range(IV_LEN, 1) : 0;
      for (int i = 0; i < IV_LEN; i++) begin
        send_beat(8'($urandom), cut == i + 1);
        if (cut == i + 1) return;
      end
      for (int i = 0; i < plen; i++) send_beat(8'($urandom), i == plen - 1);
      if (plen == 0) send_beat(8'($urandom), 1);
    end else begin
      broken = $urandom_range(5) == 0;
      cut = ($urandom_range(7) == 0) ? $urandom_range(MLEN + IV_LEN, 1) : 0;
      if ($urandom_range(15) == 0) begin
        for (int i = 0; i < 4; i++) send_beat(8'($urandom), i == 3);
        return;
      end
      for (int i = 0; i < MLEN + IV_LEN; i++) begin
        if (i < MLEN) d = MAGIC_BYTES[i];
        else d = 8'($urandom);
        if (broken && i == MLEN - 1 - ($urandom_range(3))) d = d ^ (8'h1 << $urandom_range(7));
        send_beat(d, cut == i + 1);
        if (cut == i + 1) return;
      end
      for (int i = 0; i < plen; i++) send_beat(8'($urandom), i == plen - 1);
      if (plen == 0) send_beat(8'($urandom), 1);
    end
  endtask

  // receiver stall and long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hash_chain_keystream_cipher_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: byte %h last %b bad %b empty %b",
                   out_byte, out_last, bad_format, empty_body);
      end else begin
        if (out_byte !== expected_q[0].data || out_last !== expected_q[0].last ||
            bad_format !== expected_q[0].bad || empty_body !== expected_q[0].empty) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                     expected_q[0].data, expected_q[0].last, expected_q[0].bad,
                     expected_q[0].empty, out_byte, out_last, bad_format, empty_body);
        end
        void'(expected_q.pop_front());
      end
    end
  end

  row_t rows [$];

  initial begin
    m_cipher_on = 0; m_decrypt = 0;
    foreach (m_key[i]) m_key[i] = '0;
    foreach (m_iv[i]) m_iv[i] = '0;
    foreach (m_kblk[i]) m_kblk[i] = '0;
    end_msg();

    rows = '{
      '{0, REG_CIPHER_ON, 0, 8'h00, 0, 1, '{8'h00, 0, 0, 0}},
      '{0, REG_CIPHER_ON, 0, 8'hFF, 1, 1, '{8'hFF, 1, 0, 0}},
      '{1, REG_KEY0, '1, 0, 0, 0, '{default: 0}},
      '{1, REG_KEY1, '0, 0, 0, 0, '{default: 0}},
      '{1, REG_KEY2, '1, 0, 0, 0, '{default: 0}},
      '{1, REG_KEY3, '0, 0, 0, 0, '{default: 0}},
      '{1, REG_CIPHER_ON, 1, 0, 0, 0, '{default: 0}},
      '{1, REG_DIRECTION, 64'(DIR_ENC), 0, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h80, 1, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h3C, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h01, 1, 0, '{default: 0}},
      '{1, REG_DIRECTION, 64'(!DIR_ENC), 0, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h42, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h00, 0, 1, '{8'h00, 1, 1, 0}},
      '{0, REG_CIPHER_ON, 0, 8'h11, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h22, 1, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h42, 1, 1, '{8'h00, 1, 0, 1}},
      '{0, REG_CIPHER_ON, 0, 8'h00, 1, 1, '{8'h00, 1, 1, 0}},
      '{1, REG_CIPHER_ON, 0, 0, 0, 0, '{default: 0}},
      '{0, REG_CIPHER_ON, 0, 8'h7F, 1, 1, '{8'h7F, 1, 0, 0}}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained(1);
        reg_write(rows[i].idx, rows[i].wdata);
      end else begin
        send_beat(rows[i].data, rows[i].last, rows[i].fixed, rows[i].result);
      end
    end

    for (int p = 0; p < 4; p++) begin
      gap_pct   = (p == 1) ? 74 : (p == 3) ? 37 : 0;
      stall_pct = (p == 2) ? 74 : (p == 3) ? 37 : 0;
      wait_drained(1);
      reg_write(REG_CIPHER_ON, ($urandom_range(4) != 0) ? rand64() | 1 : rand64() & ~64'h1);
      reg_write(REG_DIRECTION, rand64());
      for (int k = 0; k < 4; k++)
        reg_write(reg_idx_t'(REG_KEY0 + k), (p == 0) ? '1 : (p == 1) ? '0 : rand64());
      phase_items = 0;
      while (phase_items < 115) begin
        if (p == 1 && phase_items > 40 && phase_items < 50 && hold_cnt == 0)
          hold_cnt = 400;
        if (p == 2 && phase_items > 60 && phase_items < 70)
          wait_drained(0);
        if ($urandom_range(11) == 0) begin
          // message left open; the beats that follow continue it
          send_beat(8'($urandom), 0);
          send_beat(8'($urandom), 0);
        end else begin
          send_message();
        end
      end
    end

    wait_drained(1);
    if (errors == 0) begin
      $display("hash_chain_keystream_cipher_test: done, clean");
    end else begin
      $display("hash_chain_keystream_cipher_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
